// ----- rtl/cbts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbts_pkg
// shared widths, register indexes and status codes of the bit timing solver
// ----------------------------------------------------------------------------
package cbts_pkg;

    localparam int CLK_W      = 30;
    localparam int RATE_W     = 24;
    localparam int BRP_W      = 11;
    localparam int DIV_W      = RATE_W + BRP_W;
    localparam int PRESCALER_STEP = 1;

    localparam logic [2:0] REG_CLOCK_HZ   = 3'd0;
    localparam logic [2:0] REG_SEG1_MIN   = 3'd1;
    localparam logic [2:0] REG_SEG1_MAX   = 3'd2;
    localparam logic [2:0] REG_SEG2_MIN   = 3'd3;
    localparam logic [2:0] REG_SEG2_MAX   = 3'd4;
    localparam logic [2:0] REG_SJW_MAX    = 3'd5;
    localparam logic [2:0] REG_BRP_MIN    = 3'd6;
    localparam logic [2:0] REG_BRP_MAX    = 3'd7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;

    typedef struct packed {
        logic               start;
        logic [CLK_W-1:0]   dividend;
        logic [DIV_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [CLK_W-1:0]   quotient;
        logic               exact;
    } t_div_rsp;

endpackage
`default_nettype wire

// ----- rtl/cbts_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbts_divider
// restoring divider, one quotient bit per cycle, flags a zero remainder
// ----------------------------------------------------------------------------
module cbts_divider
    import cbts_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic [CLK_W-1:0] r_quo, n_quo;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_dvs;
    logic [4:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DIV_W:0]   w_shift;
    logic [DIV_W:0]   w_diff;

    always_comb begin
        w_shift = {r_rem, r_quo[CLK_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_cnt  = 5'(CLK_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[DIV_W]) begin
                n_rem = w_diff[DIV_W-1:0];
                n_quo = {r_quo[CLK_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[DIV_W-1:0];
                n_quo = {r_quo[CLK_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (i_req.start) begin
            r_dvs <= i_req.divisor;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
    assign o_rsp.exact    = (r_rem == '0);

endmodule
`default_nettype wire

// ----- rtl/can_bit_timing_solver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_bit_timing_solver
// searches prescalers for an exact CAN bit timing at a requested bitrate
// ----------------------------------------------------------------------------
// usage: write the eight limit registers on the config channel (i_cfg_valid,
// o_cfg_ready, i_cfg_index, i_cfg_data) while the block is idle. pulse
// i_start with i_target_bitrate while o_busy is low; the item transfers on
// that edge and o_busy rises. one result appears on the o_ ports for a
// single cycle, marked by o_done; the receiver cannot stall it.
// each prescaler trial runs a multiply step (S_MUL), the 30-step divider
// pass (S_DIV) and a check step (S_CHECK); trials go up from the lowest
// prescaler until one fits or the range ends. a zero bitrate or clock, or an
// empty prescaler range, gives its result in the cycle after the transfer.
// o_busy falls in the cycle after the result. one item at a time.
// reset returns the limit registers to their defaults and the block to idle.
// ----------------------------------------------------------------------------
module can_bit_timing_solver
    import cbts_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic [RATE_W-1:0] i_target_bitrate,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [BRP_W-1:0]       o_prescaler,
    output logic [8:0]             o_prop_segment,
    output logic [8:0]             o_phase_one,
    output logic [7:0]             o_phase_two,
    output logic [7:0]             o_jump_width
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_DIV   = 5'b00100,
        S_CHECK = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state;
    logic [CLK_W-1:0]  r_clk_hz;
    logic [8:0]        r_s1_min, r_s1_max;
    logic [7:0]        r_s2_min, r_s2_max, r_sjw_max;
    logic [BRP_W-1:0]  r_brp_min, r_brp_max;
    logic [RATE_W-1:0] r_rate;
    logic [BRP_W:0]    r_brp;
    logic [DIV_W-1:0]  r_prod;
    logic [CLK_W-1:0]  r_total;
    logic              r_exact;
    logic [1:0]        r_status;
    logic [BRP_W-1:0]  r_o_brp;
    logic [8:0]        r_o_prop, r_o_p1;
    logic [7:0]        r_o_p2, r_o_sjw;

    t_div_req w_req;
    t_div_rsp w_rsp;
    logic [DIV_W-1:0] w_prod;

    cbts_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_prod         = DIV_W'(r_rate) * DIV_W'(r_brp);
    assign w_req.start    = (r_state == S_MUL) && (w_prod != '0);
    assign w_req.dividend = r_clk_hz;
    assign w_req.divisor  = w_prod;

    // trial evaluation on registered quotient
    logic [CLK_W:0] w_lo_t, w_hi_t;
    logic [CLK_W:0] w_t2w;
    logic [7:0]     w_lo2, w_t2;
    logic [CLK_W:0] w_t1w;
    logic [8:0]     w_t1, w_p1;
    logic           w_ok;

    always_comb begin
        w_lo_t = (CLK_W+1)'(32'd1 + r_s1_min + r_s2_min);
        w_hi_t = (CLK_W+1)'(32'd1 + r_s1_max + r_s2_max);
        w_t2w  = ({1'b0, r_total} + (CLK_W+1)'(4)) >> 3;
        w_lo2  = (r_s2_min == '0) ? 8'd1 : r_s2_min;
        if (w_t2w < {23'd0, w_lo2}) begin
            w_t2 = w_lo2;
        end else if (w_t2w > {23'd0, r_s2_max}) begin
            w_t2 = r_s2_max;
        end else begin
            w_t2 = w_t2w[7:0];
        end
        w_t1w = {1'b0, r_total} - (CLK_W+1)'(32'd1 + w_t2);
        w_t1  = w_t1w[8:0];
        w_p1  = (w_t1[8:1] == '0) ? 9'd1 : {1'b0, w_t1[8:1]};
        w_ok  = r_exact
             && ({1'b0, r_total} >= w_lo_t) && ({1'b0, r_total} <= w_hi_t)
             && ({1'b0, r_total} > (CLK_W+1)'(32'd1 + w_t2))
             && (w_t1w >= {22'd0, r_s1_min}) && (w_t1w <= {22'd0, r_s1_max});
    end

    logic [BRP_W:0] w_next_brp;
    assign w_next_brp = r_brp + (BRP_W+1)'(PRESCALER_STEP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_clk_hz  <= CLK_W'(80000000);
            r_s1_min  <= 9'd1;
            r_s1_max  <= 9'd16;
            r_s2_min  <= 8'd1;
            r_s2_max  <= 8'd8;
            r_sjw_max <= 8'd4;
            r_brp_min <= 11'd1;
            r_brp_max <= 11'd1024;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_CLOCK_HZ: r_clk_hz  <= i_cfg_data[CLK_W-1:0];
                    REG_SEG1_MIN: r_s1_min  <= i_cfg_data[8:0];
                    REG_SEG1_MAX: r_s1_max  <= i_cfg_data[8:0];
                    REG_SEG2_MIN: r_s2_min  <= i_cfg_data[7:0];
                    REG_SEG2_MAX: r_s2_max  <= i_cfg_data[7:0];
                    REG_SJW_MAX:  r_sjw_max <= i_cfg_data[7:0];
                    REG_BRP_MIN:  r_brp_min <= i_cfg_data[BRP_W-1:0];
                    REG_BRP_MAX:  r_brp_max <= i_cfg_data[BRP_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_rate <= i_target_bitrate;
                        r_brp  <= {1'b0, r_brp_min};
                        r_o_brp <= '0; r_o_prop <= '0; r_o_p1 <= '0;
                        r_o_p2  <= '0; r_o_sjw  <= '0;
                        if (i_target_bitrate == '0 || r_clk_hz == '0) begin
                            r_status <= ST_INVALID;
                            r_state  <= S_OUT;
                        end else if (r_brp_min > r_brp_max) begin
                            r_status <= ST_NONE;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_prod == '0) begin
                        r_exact <= 1'b0;
                        r_state <= S_CHECK;
                    end else if (w_rsp.done) begin
                        r_total <= w_rsp.quotient;
                        r_exact <= w_rsp.exact;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_ok) begin
                        r_status <= ST_OK;
                        r_o_brp  <= r_brp[BRP_W-1:0];
                        r_o_prop <= w_t1 - w_p1;
                        r_o_p1   <= w_p1;
                        r_o_p2   <= w_t2;
                        r_o_sjw  <= (r_sjw_max < w_t2) ? r_sjw_max : w_t2;
                        r_state  <= S_OUT;
                    end else if (w_next_brp > {1'b0, r_brp_max}) begin
                        r_status <= ST_NONE;
                        r_state  <= S_OUT;
                    end else begin
                        r_brp   <= w_next_brp;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_done         = (r_state == S_OUT);
    assign o_status       = r_status;
    assign o_prescaler    = r_o_brp;
    assign o_prop_segment = r_o_prop;
    assign o_phase_one    = r_o_p1;
    assign o_phase_two    = r_o_p2;
    assign o_jump_width   = r_o_sjw;

endmodule
`default_nettype wire

// ----- tb/tb_can_bit_timing_solver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_bit_timing_solver
// self-checking bench for the CAN bit timing solver: requests bitrates under
// a series of limit settings, predicts or lists the timing result of each
// request and compares each o_done transfer field by field
// ----------------------------------------------------------------------------
module tb_can_bit_timing_solver;
    import cbts_pkg::*;

    typedef struct packed {
        logic [1:0]       status;
        logic [BRP_W-1:0] prescaler;
        logic [8:0]       prop_seg;
        logic [8:0]       phase1;
        logic [7:0]       phase2;
        logic [7:0]       sjw;
    } timing_t;

    typedef struct {
        logic [RATE_W-1:0] rate;
        bit                typed;
        timing_t           want;
    } req_row_t;

    localparam int CYCLE_LIMIT = 20000000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic [RATE_W-1:0] i_target_bitrate = '0;
    logic              i_cfg_valid = 1'b0;
    logic [2:0]        i_cfg_index = '0;
    logic [31:0]       i_cfg_data = '0;
    logic              o_busy, o_cfg_ready, o_done;
    logic [1:0]        o_status;
    logic [BRP_W-1:0]  o_prescaler;
    logic [8:0]        o_prop_segment, o_phase_one;
    logic [7:0]        o_phase_two, o_jump_width;

    // limit registers as the bench believes them to be
    logic [29:0] lim_clock;
    logic [8:0]  lim_seg1_lo, lim_seg1_hi;
    logic [7:0]  lim_seg2_lo, lim_seg2_hi, lim_sjw;
    logic [10:0] lim_brp_lo, lim_brp_hi;

    timing_t     pending_timings[$];
    int          errors = 0;
    int          cycles = 0;
    int          n_items = 0;
    int          n_solved = 0;
    int          n_unsolved = 0;

    can_bit_timing_solver DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic timing_t solve_timing(input logic [RATE_W-1:0] rate);
        timing_t         r;
        longint unsigned div, total, t2, t1, p1, lo;
        int unsigned     brp;
        r = '0;
        if (rate == 0 || lim_clock == 0) begin
            r.status = ST_INVALID;
            return r;
        end
        for (brp = lim_brp_lo; brp <= lim_brp_hi; brp += PRESCALER_STEP) begin
            div = longint'(rate) * brp;
            if (div == 0 || (longint'(lim_clock) % div) != 0)
                continue;
            total = longint'(lim_clock) / div;
            if (total < 1 + lim_seg1_lo + lim_seg2_lo || total > 1 + lim_seg1_hi + lim_seg2_hi)
                continue;
            t2 = (total + 4) >> 3;
            lo = (lim_seg2_lo < 1) ? 1 : lim_seg2_lo;
            if (t2 < lo)
                t2 = lo;
            else if (t2 > lim_seg2_hi)
                t2 = lim_seg2_hi;
            if (total <= 1 + t2)
                continue;
            t1 = total - 1 - t2;
            if (t1 < lim_seg1_lo || t1 > lim_seg1_hi)
                continue;
            p1 = (t1 / 2 < 1) ? 1 : t1 / 2;
            r.status    = ST_OK;
            r.prescaler = brp[BRP_W-1:0];
            r.prop_seg  = 9'(t1 - p1);
            r.phase1    = 9'(p1);
            r.phase2    = 8'(t2);
            r.sjw       = (lim_sjw < t2) ? lim_sjw : 8'(t2);
            return r;
        end
        r.status = ST_NONE;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        timing_t want;
        if (i_rst_n && o_done) begin
            if (pending_timings.size() == 0) begin
                report_mismatch("unexpected result, status", o_status, 0);
            end else begin
                want = pending_timings.pop_front();
                if (o_status != want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_prescaler != want.prescaler)
                    report_mismatch("prescaler", o_prescaler, want.prescaler);
                if (o_prop_segment != want.prop_seg)
                    report_mismatch("prop_segment", o_prop_segment, want.prop_seg);
                if (o_phase_one != want.phase1)
                    report_mismatch("phase_one", o_phase_one, want.phase1);
                if (o_phase_two != want.phase2)
                    report_mismatch("phase_two", o_phase_two, want.phase2);
                if (o_jump_width != want.sjw)
                    report_mismatch("jump_width", o_jump_width, want.sjw);
                if (want.status == ST_OK)
                    n_solved++;
                else
                    n_unsolved++;
            end
        end
    end

    task automatic write_limit(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_CLOCK_HZ: lim_clock   = value[29:0];
            REG_SEG1_MIN: lim_seg1_lo = value[8:0];
            REG_SEG1_MAX: lim_seg1_hi = value[8:0];
            REG_SEG2_MIN: lim_seg2_lo = value[7:0];
            REG_SEG2_MAX: lim_seg2_hi = value[7:0];
            REG_SJW_MAX:  lim_sjw     = value[7:0];
            REG_BRP_MIN:  lim_brp_lo  = value[10:0];
            REG_BRP_MAX:  lim_brp_hi  = value[10:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_timings.size() != 0 || o_busy)
            @(posedge i_clk);
    endtask

    // one request transfer; returns once accepted
    task automatic request_timing(input logic [RATE_W-1:0] rate, input bit typed,
                                  input timing_t want);
        int gap;
        gap = pick_gap();
        repeat (gap) @(negedge i_clk);
        @(negedge i_clk);
        i_start = 1'b1;
        i_target_bitrate = rate;
        do @(posedge i_clk); while (o_busy);
        pending_timings.push_back(typed ? want : solve_timing(rate));
        n_items++;
        @(negedge i_clk);
        i_start = 1'b0;
        i_target_bitrate = RATE_W'($urandom());
    endtask

    task automatic apply_limits(input int phase);
        logic [31:0] clk_hz;
        logic [31:0] s1lo, s1hi, s2lo, s2hi, sjw, blo, bhi;
        int          sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0: clk_hz = 80000000;
            1: clk_hz = 48000000;
            2: clk_hz = 40000000;
            3: clk_hz = 24000000;
            4: clk_hz = 16000000;
            default: clk_hz = $urandom_range(1, 30'h3FFF_FFFF);
        endcase
        s1lo = $urandom_range(1, 4);
        s1hi = $urandom_range(s1lo, 40);
        s2lo = $urandom_range(1, 3);
        s2hi = $urandom_range(s2lo, 16);
        sjw  = $urandom_range(1, 8);
        blo  = $urandom_range(1, 16);
        bhi  = blo + $urandom_range(0, 48);
        case (phase)
            0: begin
                // wide segment limits
                clk_hz = 1000000000;
                s1lo = 1; s1hi = 256; s2lo = 1; s2hi = 128; sjw = 128;
            end
            1: begin
                // crossed segment 2 limits
                s2lo = 20; s2hi = 3;
            end
            2: begin
                // empty prescaler range
                blo = 50; bhi = 10;
            end
            3: clk_hz = 0;
            4: begin
                // zero prescaler trial, narrow segments
                blo = 0; s1lo = 2; s1hi = 2; s2lo = 1; s2hi = 1; sjw = 1;
            end
            5: begin
                // largest clock, large fixed segment and prescaler limits
                clk_hz = 30'h3FFF_FFFF; s1lo = 256; s1hi = 256;
                s2lo = 128; s2hi = 128; sjw = 128; blo = 1000; bhi = 1024;
            end
            6: begin
                s1lo = 9'h1FF; s1hi = 9'h1FF; s2lo = 8'hFF; s2hi = 8'hFF;
                sjw = 8'hFF; blo = 11'h7FF; bhi = 11'h7FF;
            end
            default: ;
        endcase
        write_limit(REG_CLOCK_HZ, clk_hz);
        write_limit(REG_SEG1_MIN, s1lo);
        write_limit(REG_SEG1_MAX, s1hi);
        write_limit(REG_SEG2_MIN, s2lo);
        write_limit(REG_SEG2_MAX, s2hi);
        write_limit(REG_SJW_MAX, sjw);
        write_limit(REG_BRP_MIN, blo);
        write_limit(REG_BRP_MAX, bhi);
    endtask

    // bitrate from the clock over a prescaler and a plausible quanta count, or noise
    function automatic logic [RATE_W-1:0] pick_rate();
        longint unsigned brp, total, rate;
        if ($urandom_range(0, 3) == 0)
            return RATE_W'($urandom());
        brp   = ((lim_brp_lo == 0) ? 1 : lim_brp_lo) + $urandom_range(0, 7);
        total = $urandom_range(3, 40);
        rate  = longint'(lim_clock) / (brp * total);
        if (rate == 0 || rate > 24'hFF_FFFF)
            return RATE_W'($urandom_range(1, 24'hFF_FFFF));
        return rate[RATE_W-1:0];
    endfunction

    req_row_t reset_rows[10];

    initial begin
        timing_t none_t;
        none_t = '0;
        lim_clock = 80000000; lim_seg1_lo = 1; lim_seg1_hi = 16;
        lim_seg2_lo = 1; lim_seg2_hi = 8; lim_sjw = 4;
        lim_brp_lo = 1; lim_brp_hi = 1024;

        reset_rows[0] = '{24'd0, 1'b1, '{ST_INVALID, 11'd0, 9'd0, 9'd0, 8'd0, 8'd0}};
        reset_rows[1] = '{24'd500000, 1'b1, '{ST_OK, 11'd8, 9'd8, 9'd8, 8'd3, 8'd3}};
        reset_rows[2] = '{24'd1000000, 1'b0, none_t};
        reset_rows[3] = '{24'd250000, 1'b0, none_t};
        reset_rows[4] = '{24'd125000, 1'b0, none_t};
        reset_rows[5] = '{24'hFF_FFFF, 1'b0, none_t};
        reset_rows[6] = '{24'd1, 1'b0, none_t};
        reset_rows[7] = '{24'hAA_AAAA, 1'b0, none_t};
        reset_rows[8] = '{24'h55_5555, 1'b0, none_t};
        reset_rows[9] = '{24'd20000, 1'b0, none_t};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (reset_rows[k])
            request_timing(reset_rows[k].rate, reset_rows[k].typed, reset_rows[k].want);
        // hold off until everything is back
        wait_drained();

        for (int phase = 0; phase < 9; phase++) begin
            wait_drained();
            apply_limits(phase);
            if (phase == 3)
                request_timing(24'd500000, 1'b1, '{ST_INVALID, 11'd0, 9'd0, 9'd0, 8'd0, 8'd0});
            if (phase == 2)
                request_timing(24'd500000, 1'b1, '{ST_NONE, 11'd0, 9'd0, 9'd0, 8'd0, 8'd0});
            for (int n = 0; n < 10; n++)
                request_timing(pick_rate(), 1'b0, none_t);
        end

        wait_drained();
        repeat (100) @(posedge i_clk);
        $display("%0d bitrate requests over 10 limit settings: %0d solved, %0d unsolved",
                 n_items, n_solved, n_unsolved);
        if (errors == 0 && pending_timings.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, pending_timings.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cbts_pkg.sv
rtl/cbts_divider.sv
rtl/can_bit_timing_solver.sv
tb/tb_can_bit_timing_solver.sv
